@@ hw/rtl/band_peak_hysteresis_detector_macros.svh @@
// Assertion macros of the band peak detector RTL, used by bphd_peak_decide.
`ifndef BAND_PEAK_HYSTERESIS_DETECTOR_MACROS_SVH
`define BAND_PEAK_HYSTERESIS_DETECTOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BPHD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BPHD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/bphd_pkg.sv @@
// Types and constants of the band peak hysteresis detector.
`default_nettype none
package bphd_pkg;

  localparam int unsigned MagW  = 32;
  localparam int unsigned TimeW = 32;
  localparam int unsigned DebW  = 16;
  localparam int unsigned BinW  = 8;
  localparam int unsigned IdxW  = 9;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // Bins at or above this index never count toward the peak.
  localparam int unsigned HALF_BINS = 256;
  localparam logic [IdxW-1:0] IdxMax = '1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ON_THR   = 3'd0,
    REG_OFF_THR  = 3'd1,
    REG_DEBOUNCE = 3'd2,
    REG_BAND_LO  = 3'd3,
    REG_BAND_HI  = 3'd4
  } cfg_reg_e;

  localparam logic [MagW-1:0]  OnThrRst   = 32'd89600;
  localparam logic [MagW-1:0]  OffThrRst  = 32'd76800;
  localparam logic [DebW-1:0]  DebounceRst = 16'd200;
  localparam logic [BinW-1:0]  BandLoRst  = 8'd155;
  localparam logic [BinW-1:0]  BandHiRst  = 8'd169;

  typedef struct packed {
    logic [MagW-1:0]  on_thr;
    logic [MagW-1:0]  off_thr;
    logic [DebW-1:0]  debounce;
    logic [BinW-1:0]  band_lo;
    logic [BinW-1:0]  band_hi;
  } cfg_t;

  typedef struct packed {
    logic [MagW-1:0]  magnitude;
    logic             last_bin;
    logic [TimeW-1:0] now_ms;
  } bin_item_t;

endpackage
`default_nettype wire

@@ hw/rtl/band_peak_hysteresis_detector.sv @@
// Top level of the spectral band peak detector with hysteresis and debounce.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata {now_ms, magnitude}, tlast last_bin
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata band_peak, tuser active
//  cfg       in   cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
// One bin word is taken per cycle while no stalled result holds a last bin word; a result
// leaves through the input register and then the result register. The peak and decision
// logic between them updates the frame state once per word.
// A stalled result holds the next last bin word in the input register; input stalls behind it.
// Reset restores the register defaults, clears the frame state and leaves the block inactive.
`default_nettype none
module band_peak_hysteresis_detector
  import bphd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [MagW+TimeW-1:0] s_axis_tdata,   // magnitude[31:0], now_ms[63:32]
  input  wire logic                  s_axis_tlast,   // last_bin
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [MagW-1:0]            m_axis_tdata,   // band_peak[31:0]
  output logic                       m_axis_tuser,   // active
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [CfgDataW-1:0]   cfg_data_i
);

  cfg_t      cfg;
  bin_item_t in_item;
  bin_item_t held_item;
  logic      held_valid;
  logic      take;

  assign cfg_ready_o = 1'b1;

  bphd_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  assign in_item.magnitude = s_axis_tdata[MagW-1:0];
  assign in_item.now_ms    = s_axis_tdata[MagW+TimeW-1:MagW];
  assign in_item.last_bin  = s_axis_tlast;

  bphd_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .valid_o (held_valid),
    .take_i  (take),
    .item_o  (held_item)
  );

  bphd_peak_decide u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .valid_i      (held_valid),
    .item_i       (held_item),
    .take_o       (take),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_active_o (m_axis_tuser),
    .res_peak_o   (m_axis_tdata)
  );

endmodule
`default_nettype wire

@@ hw/rtl/bphd_cfg_regs.sv @@
// Configuration register file of the band peak detector.
`default_nettype none
module bphd_cfg_regs
  import bphd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                wr_en_i,
  input  wire logic [CfgIdxW-1:0]  wr_idx_i,
  input  wire logic [CfgDataW-1:0] wr_data_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_idx_i)
        REG_ON_THR:   cfg_d.on_thr   = wr_data_i[MagW-1:0];
        REG_OFF_THR:  cfg_d.off_thr  = wr_data_i[MagW-1:0];
        REG_DEBOUNCE: cfg_d.debounce = wr_data_i[DebW-1:0];
        REG_BAND_LO:  cfg_d.band_lo  = wr_data_i[BinW-1:0];
        REG_BAND_HI:  cfg_d.band_hi  = wr_data_i[BinW-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.on_thr   <= OnThrRst;
      cfg_q.off_thr  <= OffThrRst;
      cfg_q.debounce <= DebounceRst;
      cfg_q.band_lo  <= BandLoRst;
      cfg_q.band_hi  <= BandHiRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

@@ hw/rtl/bphd_in_stage.sv @@
// Input register of the band peak detector.
`default_nettype none
module bphd_in_stage
  import bphd_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      valid_i,
  output logic           ready_o,
  input  wire bin_item_t item_i,
  output logic           valid_o,
  input  wire logic      take_i,
  output bin_item_t      item_o
);

  logic      valid_q, valid_d;
  bin_item_t item_q;

  // Refill in the same cycle the held word is consumed.
  assign ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule
`default_nettype wire

@@ hw/rtl/bphd_peak_decide.sv @@
// Band peak tracking, hysteresis decision and result register.
`default_nettype none
module bphd_peak_decide
  import bphd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cfg_t              cfg_i,
  input  wire logic              valid_i,
  input  wire bin_item_t         item_i,
  output logic                   take_o,
  output logic                   res_valid_o,
  input  wire logic              res_ready_i,
  output logic                   res_active_o,
  output logic [MagW-1:0]        res_peak_o
);

  `include "band_peak_hysteresis_detector_macros.svh"

  logic [IdxW-1:0]  bin_idx_q, bin_idx_d;
  logic [MagW-1:0]  peak_q, peak_d;
  logic             act_q, act_d;
  logic [TimeW-1:0] last_chg_q, last_chg_d;
  logic             res_valid_q, res_valid_d;
  logic             res_active_q;
  logic [MagW-1:0]  res_peak_q;

  logic             out_free;
  logic             in_band;
  logic [MagW-1:0]  frame_peak;
  logic             want_state;
  logic [TimeW-1:0] elapsed;
  logic             debounced;

  assign out_free = !res_valid_q || res_ready_i;
  // A last word needs a free result slot; other words always pass.
  assign take_o   = valid_i && (!item_i.last_bin || out_free);

  assign in_band = (bin_idx_q >= {1'b0, cfg_i.band_lo}) &&
                   (bin_idx_q <= {1'b0, cfg_i.band_hi}) &&
                   (32'(bin_idx_q) < HALF_BINS);

  assign frame_peak = (in_band && (item_i.magnitude > peak_q)) ? item_i.magnitude : peak_q;

  always_comb begin
    want_state = act_q;
    if (!act_q && (frame_peak > cfg_i.on_thr)) begin
      want_state = 1'b1;
    end else if (act_q && (frame_peak < cfg_i.off_thr)) begin
      want_state = 1'b0;
    end
  end

  // Elapsed time wraps modulo 2^32.
  assign elapsed   = item_i.now_ms - last_chg_q;
  assign debounced = elapsed >= {{(TimeW-DebW){1'b0}}, cfg_i.debounce};

  always_comb begin
    bin_idx_d   = bin_idx_q;
    peak_d      = peak_q;
    act_d       = act_q;
    last_chg_d  = last_chg_q;
    res_valid_d = res_valid_q;
    if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
    if (take_o) begin
      if (item_i.last_bin) begin
        bin_idx_d   = '0;
        peak_d      = '0;
        res_valid_d = 1'b1;
        if (want_state != act_q) begin
          if (debounced) begin
            act_d      = want_state;
            last_chg_d = item_i.now_ms;
          end
        end else begin
          last_chg_d = item_i.now_ms;
        end
      end else begin
        peak_d = frame_peak;
        if (bin_idx_q != IdxMax) begin
          bin_idx_d = bin_idx_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_idx_q   <= '0;
      peak_q      <= '0;
      act_q       <= 1'b0;
      last_chg_q  <= '0;
      res_valid_q <= 1'b0;
    end else begin
      bin_idx_q   <= bin_idx_d;
      peak_q      <= peak_d;
      act_q       <= act_d;
      last_chg_q  <= last_chg_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && item_i.last_bin) begin
      res_active_q <= act_d;
      res_peak_q   <= frame_peak;
    end
  end

  assign res_valid_o  = res_valid_q;
  assign res_active_o = res_active_q;
  assign res_peak_o   = res_peak_q;

  `BPHD_ASSERT_NEXT(a_frame_restart, clk_i, rst_ni, take_o && item_i.last_bin,
    bin_idx_q == '0 && peak_q == '0, "frame state not cleared after last bin")
  `BPHD_ASSERT_NEXT(a_change_stamps_time, clk_i, rst_ni,
    take_o && item_i.last_bin && (act_d != act_q),
    last_chg_q == $past(item_i.now_ms), "state change did not record its time")
  `BPHD_ASSERT_NEXT(a_idx_monotonic, clk_i, rst_ni, take_o && !item_i.last_bin,
    bin_idx_q >= $past(bin_idx_q), "bin counter went backward inside a frame")
  `BPHD_ASSERT_NOW(a_empty_band_zero, clk_i, rst_ni,
    take_o && item_i.last_bin && (cfg_i.band_lo > cfg_i.band_hi),
    frame_peak == '0, "empty band produced a nonzero peak")

endmodule
`default_nettype wire

@@ verif/bphd_checker.sv @@
// Tracks the band peak detector from its channels and checks every decision word.
`timescale 1ns / 1ps
module bphd_checker
  import bphd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [MagW+TimeW-1:0] s_axis_tdata,   // magnitude, now_ms
  input  logic                  s_axis_tlast,   // last_bin
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [MagW-1:0]       m_axis_tdata,   // band_peak
  input  logic                  m_axis_tuser,   // active
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_o,
  input  logic [CfgIdxW-1:0]    cfg_index_i,
  input  logic [CfgDataW-1:0]   cfg_data_i,
  output int                    fail_cnt_o,
  output int                    pending_o
);

  localparam int ReportMax = 10;

  typedef struct packed {
    logic            active;
    logic [MagW-1:0] band_peak;
  } decision_t;

  cfg_t             regs;
  logic [IdxW-1:0]  bin_idx;
  logic [MagW-1:0]  frame_peak;
  logic             active_q;
  logic [TimeW-1:0] stamp_ms;
  decision_t        decision_q[$];
  int               errs;

  function automatic logic bin_in_band(input logic [IdxW-1:0] idx);
    return (idx >= regs.band_lo) && (idx <= regs.band_hi) && (idx < HALF_BINS);
  endfunction

  // One accepted bin word; a last bin closes the frame and queues its decision.
  task automatic track_bin(input logic [MagW-1:0] mag, input logic last,
                           input logic [TimeW-1:0] now);
    logic             want;
    logic [TimeW-1:0] elapsed;
    decision_t        d;
    if (bin_in_band(bin_idx) && mag > frame_peak) frame_peak = mag;
    if (!last) begin
      if (bin_idx != IdxMax) bin_idx = bin_idx + 1'b1;
    end else begin
      want = active_q;
      if (!active_q && frame_peak > regs.on_thr) want = 1'b1;
      else if (active_q && frame_peak < regs.off_thr) want = 1'b0;
      elapsed = now - stamp_ms;
      if (want != active_q) begin
        if (elapsed >= regs.debounce) begin
          active_q = want;
          stamp_ms = now;
        end
      end else begin
        // a steady decision refreshes the debounce reference
        stamp_ms = now;
      end
      d.active    = active_q;
      d.band_peak = frame_peak;
      decision_q.push_back(d);
      bin_idx    = '0;
      frame_peak = '0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    decision_t d;
    if (!rst_ni) begin
      regs.on_thr   = OnThrRst;
      regs.off_thr  = OffThrRst;
      regs.debounce = DebounceRst;
      regs.band_lo  = BandLoRst;
      regs.band_hi  = BandHiRst;
      bin_idx       = '0;
      frame_peak    = '0;
      active_q      = 1'b0;
      stamp_ms      = '0;
      decision_q.delete();
      errs          = 0;
      fail_cnt_o   <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_ON_THR:   regs.on_thr   = cfg_data_i[MagW-1:0];
          REG_OFF_THR:  regs.off_thr  = cfg_data_i[MagW-1:0];
          REG_DEBOUNCE: regs.debounce = cfg_data_i[DebW-1:0];
          REG_BAND_LO:  regs.band_lo  = cfg_data_i[BinW-1:0];
          REG_BAND_HI:  regs.band_hi  = cfg_data_i[BinW-1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (decision_q.size() == 0) begin
          errs++;
          if (errs <= ReportMax)
            $display("%0t: unexpected word: active %0b band_peak 0x%08h",
                     $realtime, m_axis_tuser, m_axis_tdata);
        end else begin
          d = decision_q.pop_front();
          if (m_axis_tuser !== d.active || m_axis_tdata !== d.band_peak) begin
            errs++;
            if (errs <= ReportMax)
              $display("%0t: mismatch: active exp %0b got %0b, band_peak exp 0x%08h got 0x%08h",
                       $realtime, d.active, m_axis_tuser, d.band_peak, m_axis_tdata);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        track_bin(s_axis_tdata[MagW-1:0], s_axis_tlast, s_axis_tdata[MagW +: TimeW]);
      fail_cnt_o <= errs;
      pending_o  <= decision_q.size();
    end
  end

endmodule

@@ verif/tb_band_peak_hysteresis_detector.sv @@
// Stimulus and verdict for the band peak hysteresis detector.
`timescale 1ns / 1ps
module tb_band_peak_hysteresis_detector;
  import bphd_pkg::*;

  localparam int unsigned LongHold    = 300;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned NumPhases   = 10;
  localparam int unsigned CycleLimit  = 400000;
  localparam logic [CfgIdxW-1:0] FirstUnusedReg = CfgIdxW'(REG_BAND_HI + 1);
  localparam logic [MagW-1:0] DirOn  = 32'd1000;
  localparam logic [MagW-1:0] DirOff = 32'd500;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [MagW+TimeW-1:0] s_axis_tdata = '0;   // magnitude, now_ms
  logic                  s_axis_tlast = 1'b0; // last_bin
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [MagW-1:0]       m_axis_tdata;        // band_peak
  logic                  m_axis_tuser;        // active
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CfgIdxW-1:0]    cfg_index_i = '0;
  logic [CfgDataW-1:0]   cfg_data_i = '0;

  int               fails;
  int               pending;
  int unsigned      cycle_cnt = 0;
  cfg_t             cur;
  logic [TimeW-1:0] wall_ms;
  bit               calm = 1'b0;
  bit               hold_arm = 1'b0;
  bit               hold_done = 1'b0;

  always #5 clk_i = ~clk_i;

  band_peak_hysteresis_detector u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  bphd_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fail_cnt_o    (fails),
    .pending_o     (pending)
  );

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: random back-pressure, one long hold-off when armed, none once calm.
  initial begin : rx_side
    int unsigned span;
    logic        lvl;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_arm && !hold_done) begin
        lvl       = 1'b0;
        span      = LongHold;
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        lvl  = 1'b0;
        span = $urandom_range(1, 9);
      end else begin
        lvl  = 1'b1;
        span = $urandom_range(1, 24);
      end
      m_axis_tready <= lvl;
      repeat (span) @(posedge clk_i);
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Junk upper bits on the narrow registers, plus a write to an unused index.
  task automatic configure(input cfg_t c);
    write_reg(CfgIdxW'($urandom_range(FirstUnusedReg, (1 << CfgIdxW) - 1)), $urandom());
    write_reg(REG_ON_THR, c.on_thr);
    write_reg(REG_OFF_THR, c.off_thr);
    write_reg(REG_DEBOUNCE, {(CfgDataW-DebW)'($urandom()), c.debounce});
    write_reg(REG_BAND_LO, {(CfgDataW-BinW)'($urandom()), c.band_lo});
    write_reg(REG_BAND_HI, {(CfgDataW-BinW)'($urandom()), c.band_hi});
    cfg_valid_i <= 1'b0;
    cur = c;
  endtask

  task automatic send_bin(input logic [MagW-1:0] mag, input logic last,
                          input logic [TimeW-1:0] now);
    int unsigned gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= {$urandom(), $urandom()};
      s_axis_tlast  <= 1'($urandom());
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {now, mag};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Lets every queued decision arrive, then the pipe run dry of non-last bins.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [MagW-1:0] pick_mag(input logic [MagW-1:0] ceil_mag);
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return '1;
      2:       return $urandom();
      default: return $urandom_range(0, ceil_mag);
    endcase
  endfunction

  // Bins from loud_from on get words with the top bit set, to catch index wrap.
  task automatic send_frame(input int unsigned len, input logic [MagW-1:0] ceil_mag,
                            input int unsigned loud_from);
    int unsigned      i;
    logic [MagW-1:0]  mag;
    for (i = 0; i < len; i++) begin
      if (i >= loud_from) mag = {1'b1, 31'($urandom())};
      else mag = pick_mag(ceil_mag);
      if (i + 1 == len) begin
        case ($urandom_range(0, 19))
          0:       wall_ms = $urandom();
          1:       wall_ms = wall_ms + cur.debounce;
          default: wall_ms = wall_ms + $urandom_range(0, 2 * int'(cur.debounce) + 4);
        endcase
        send_bin(mag, 1'b1, wall_ms);
      end else begin
        send_bin(mag, 1'b0, $urandom());
      end
    end
  endtask

  initial begin : stimulus
    int unsigned      k;
    int unsigned      budget;
    int unsigned      sent;
    int unsigned      len;
    logic [MagW-1:0]  on;
    logic [MagW-1:0]  off;
    logic [MagW-1:0]  span;
    logic [MagW-1:0]  ceil_mag;
    logic [DebW-1:0]  deb;
    logic [BinW-1:0]  lo;
    logic [BinW-1:0]  hi;
    cfg_t             nxt;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fields: on, off, debounce, band low, band high
    configure(cfg_t'({DirOn, DirOff, 16'd100, 8'd0, 8'd3}));
    send_bin(DirOn, 1'b1, 32'd50);          // peak equal to on level stays off
    send_bin('0, 1'b0, $urandom());
    send_bin(DirOn + 1, 1'b1, 32'd149);     // one ms short of debounce
    send_bin(DirOn + 1, 1'b1, 32'd150);     // turns on
    send_bin(DirOff, 1'b1, 32'd151);        // equal to off level holds
    send_bin(DirOff - 1, 1'b1, 32'd250);    // too early to drop
    send_bin('0, 1'b1, 32'd251);            // turns off
    send_bin(32'd16, 1'b0, $urandom());
    send_bin(DirOn + 200, 1'b0, $urandom());
    send_bin(32'd7, 1'b0, $urandom());
    send_bin('0, 1'b0, $urandom());          // upper band edge
    send_bin('1, 1'b1, 32'hFFFF_FFC0);       // out of band, frame turns on
    send_bin('0, 1'b1, 32'h0000_0023);       // 99 ms across the time wrap
    send_bin('0, 1'b1, 32'h0000_0024);       // 100 ms across the wrap: off
    send_bin('1, 1'b0, $urandom());
    send_bin(32'd5, 1'b1, 32'h0000_0024);    // full-scale peak, debounce blocks
    wall_ms = 32'h0000_0024;

    for (k = 0; k < NumPhases; k++) begin
      settle();
      on     = $urandom_range(64, 200000);
      off    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 250000) : $urandom_range(0, on);
      deb    = DebW'($urandom_range(0, 400));
      lo     = BinW'($urandom_range(0, 10));
      hi     = BinW'(lo + $urandom_range(0, 14));
      budget = 100;
      case (k)
        0: begin
          on = '0; off = '0; deb = '0; lo = '0; hi = '1; budget = 120;
        end
        1: begin
          on = '1; off = '1; deb = '1; lo = '1; hi = '1; budget = 60;
        end
        2: begin
          // empty band
          lo = BinW'($urandom_range(1, 255));
          hi = BinW'($urandom_range(0, lo - 1));
        end
        3: begin
          lo = '0; hi = '1; budget = 80;
        end
        default: ;
      endcase
      nxt = {on, off, deb, lo, hi};
      configure(nxt);
      if (k == 5) hold_arm = 1'b1;
      if (k == NumPhases - 1) calm = 1'b1;
      if (k == 1) send_frame(260, $urandom(), 260);
      if (k == 3) send_frame(530, 32'h0000_FFFF, HALF_BINS);
      sent = 0;
      while (sent < budget) begin
        len  = $urandom_range(1, 26);
        span = (cur.on_thr > cur.off_thr) ? cur.on_thr : cur.off_thr;
        case ($urandom_range(0, 2))
          0:       ceil_mag = cur.off_thr;
          1:       ceil_mag = span;
          default: ceil_mag = (span > 32'h7FFF_FFFF) ? '1 : span * 2 + 2;
        endcase
        send_frame(len, ceil_mag, len);
        sent += len;
      end
    end

    settle();
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
